>>> rtl/core/pwc_pkg.sv
// Shared types and constants for the polygon window clipper.
package pwc_pkg;

  localparam int CW     = 32;          // coordinate width
  localparam int DW     = CW + 1;      // width of a coordinate difference
  localparam int T_FRAC = 30;          // fraction bits of an edge parameter
  localparam int TW     = 63;          // signed edge parameter width
  localparam int QW     = 62;          // saturated quotient magnitude width
  localparam int PW     = 2 * CW;      // product width of the multiply-divide unit

  localparam logic [QW-1:0]        T_SAT = {QW{1'b1}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << T_FRAC;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_X_MAX = 2'd1;
  localparam logic [1:0] REG_Y_MIN = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  // Request to the shared multiply-divide unit: floor(a*b/c), c non-zero.
  typedef struct packed {
    logic          start;
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
  } md_req_t;

  // Response from the shared multiply-divide unit.
  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] q;
  } md_rsp_t;

endpackage

>>> rtl/core/polygon_window_clipper.sv
// Top level of the polygon window clipper: edge sequencer and output register.
// A vertex is taken only in the idle state; each later vertex of a polygon clips one edge, the last
// vertex two unless it repeats the first, and each edge needs up to six divisions of the shared unit.
// Throughput: one vertex at a time; the shared multiply-divide unit, producing one
// quotient bit per cycle, sets the figure. The output register frees the result side.
// Reset (rst, synchronous): window registers, vertex history and the output valid clear.
module polygon_window_clipper
  import pwc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [CW-1:0] cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // in_x [31:0], in_y [63:32]
  input  logic          s_tlast,   // in_last
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,   // out_x [31:0], out_y [63:32]
  output logic [1:0]    m_tuser,   // generated [0], empty_res [1]
  output logic          m_tlast    // polygon_end
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_PAR_START, S_PAR_WAIT, S_DEC_IN, S_IN2, S_DEC_OUT,
    S_CR_START, S_CR_WAIT, S_OUT_PT, S_EMIT, S_EDGE_DONE, S_FINAL
  } state_t;

  state_t state, ret;

  logic signed [CW-1:0] win_x_min, win_x_max, win_y_min, win_y_max;
  logic signed [CW-1:0] prev_x, prev_y, start_x, start_y, cur_x, cur_y;
  logic signed [CW-1:0] first_out_x, first_out_y;
  logic                 first_out_gen, have_prev, any_output, cur_last, closing;
  logic signed [CW-1:0] e_x1, e_y1, e_x2, e_y2;
  logic signed [CW-1:0] x1, y1, x2, y2, xin, xout, yin, yout;
  logic signed [DW-1:0] dx, dy, nix, niy, nox, noy;
  logic                 px, py;
  logic [1:0]           pi;
  logic signed [TW-1:0] tinx, tiny, toutx, touty;
  logic                 cr_out;
  logic signed [CW-1:0] em_x, em_y;
  logic                 em_gen;
  md_req_t              md_req;
  md_rsp_t              md_rsp;
  logic                 out_free;
  logic                 out_load;

  pwc_muldiv u_muldiv (.clk(clk), .rst(rst), .req(md_req), .rsp(md_rsp));

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_EMIT || state == S_FINAL);

  // On-edge nudge of an edge coordinate.
  function automatic logic signed [CW-1:0] nudge(input logic signed [CW-1:0] c,
                                                 input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi);
    return ((c == lo || c == hi) && c != C_MAX) ? c + CW'(1) : c;
  endfunction

  function automatic logic [CW-1:0] magn(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v[DW-1] ? -v : v;
    return a[CW-1:0];
  endfunction

  // Nudged endpoints and edge deltas of the current edge.
  logic signed [CW-1:0] n_x1, n_y1, n_x2, n_y2;
  logic signed [DW-1:0] n_dx, n_dy;
  logic                 n_px, n_py;
  logic signed [CW-1:0] n_xin, n_xout, n_yin, n_yout;
  always_comb begin
    n_x1   = nudge(e_x1, win_x_min, win_x_max);
    n_x2   = nudge(e_x2, win_x_min, win_x_max);
    n_y1   = nudge(e_y1, win_y_min, win_y_max);
    n_y2   = nudge(e_y2, win_y_min, win_y_max);
    n_dx   = DW'(n_x2) - DW'(n_x1);
    n_dy   = DW'(n_y2) - DW'(n_y1);
    n_px   = (n_dx > 0) || (n_dx == 0 && !(n_x1 > win_x_min));
    n_py   = (n_dy > 0) || (n_dy == 0 && !(n_y1 > win_y_min));
    n_xin  = n_px ? win_x_min : win_x_max;
    n_xout = n_px ? win_x_max : win_x_min;
    n_yin  = n_py ? win_y_min : win_y_max;
    n_yout = n_py ? win_y_max : win_y_min;
  end

  // Operand selection for the parameter being worked on.
  logic signed [DW-1:0] p_num, p_den;
  logic                 p_pos, p_neg;
  logic [QW-1:0]        p_mag;
  logic signed [TW-1:0] p_val;
  always_comb begin
    unique case (pi)
      2'd0:    begin p_num = nix; p_den = dx; p_pos = px; end
      2'd1:    begin p_num = niy; p_den = dy; p_pos = py; end
      2'd2:    begin p_num = nox; p_den = dx; p_pos = px; end
      default: begin p_num = noy; p_den = dy; p_pos = py; end
    endcase
    p_neg = (p_num[DW-1] == p_pos);
    p_mag = (p_den == 0) ? T_SAT : md_rsp.q;
    p_val = p_neg ? -TW'(p_mag) : TW'(p_mag);
  end

  // Entry and exit decisions.
  logic signed [TW-1:0] tin1, tin2, tout1;
  assign tin1  = (tinx < tiny) ? tinx : tiny;
  assign tin2  = (tinx < tiny) ? tiny : tinx;
  assign tout1 = (toutx < touty) ? toutx : touty;

  // Intersection operands: ax set means x is fixed and y is computed.
  logic                 ax, c_neg, c_zero;
  logic signed [CW-1:0] c_base, c_fix;
  logic signed [DW-1:0] c_num, c_oth, c_own;
  logic signed [63:0]   c_sum;
  logic signed [CW-1:0] c_val;
  always_comb begin
    ax = cr_out ? (toutx < touty) : (tinx > tiny);
    if (ax) begin
      c_base = y1; c_num = cr_out ? nox : nix; c_oth = dy; c_own = dx;
      c_fix  = cr_out ? xout : xin;
    end else begin
      c_base = x1; c_num = cr_out ? noy : niy; c_oth = dx; c_own = dy;
      c_fix  = cr_out ? yout : yin;
    end
    c_zero = (c_own == 0) || (c_num == 0) || (c_oth == 0);
    c_neg  = (c_num[DW-1] != c_oth[DW-1]) != c_own[DW-1];
    c_sum  = c_neg ? 64'(c_base) - 64'(md_rsp.q) : 64'(c_base) + 64'(md_rsp.q);
    if (c_sum > 64'(C_MAX))      c_val = C_MAX;
    else if (c_sum < 64'(C_MIN)) c_val = C_MIN;
    else                         c_val = c_sum[CW-1:0];
  end

  // Requests to the shared unit.
  always_comb begin
    md_req.start = 1'b0;
    md_req.a     = magn(p_num);
    md_req.b     = CW'(T_ONE);
    md_req.c     = magn(p_den);
    if (state == S_PAR_START) begin
      md_req.start = (p_num != 0) && (p_den != 0);
    end else if (state == S_CR_START) begin
      md_req.start = !c_zero;
      md_req.a     = magn(c_num);
      md_req.b     = magn(c_oth);
      md_req.c     = magn(c_own);
    end
  end

  // Sequencer, vertex history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      win_x_min  <= '0;
      win_x_max  <= '0;
      win_y_min  <= '0;
      win_y_max  <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      start_x    <= '0;
      start_y    <= '0;
      first_out_x <= '0;
      first_out_y <= '0;
      first_out_gen <= 1'b0;
      have_prev  <= 1'b0;
      any_output <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      // The user must write configuration only while idle; the block itself does not enforce this.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_MIN: win_x_min <= cfg_data;
          REG_X_MAX: win_x_max <= cfg_data;
          REG_Y_MIN: win_y_min <= cfg_data;
          REG_Y_MAX: win_y_max <= cfg_data;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_x    <= s_tdata[31:0];
            cur_y    <= s_tdata[63:32];
            cur_last <= s_tlast;
            closing  <= 1'b0;
            prev_x   <= s_tdata[31:0];
            prev_y   <= s_tdata[63:32];
            e_x1     <= prev_x;
            e_y1     <= prev_y;
            e_x2     <= s_tdata[31:0];
            e_y2     <= s_tdata[63:32];
            if (!have_prev) begin
              start_x   <= s_tdata[31:0];
              start_y   <= s_tdata[63:32];
              have_prev <= 1'b1;
              state     <= s_tlast ? S_FINAL : S_IDLE;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          x1 <= n_x1; y1 <= n_y1; x2 <= n_x2; y2 <= n_y2;
          dx <= n_dx; dy <= n_dy; px <= n_px; py <= n_py;
          xin <= n_xin; xout <= n_xout; yin <= n_yin; yout <= n_yout;
          nix <= DW'(n_xin) - DW'(n_x1);
          niy <= DW'(n_yin) - DW'(n_y1);
          nox <= DW'(n_xout) - DW'(n_x1);
          noy <= DW'(n_yout) - DW'(n_y1);
          pi    <= 2'd0;
          state <= S_PAR_START;
        end
        S_PAR_START, S_PAR_WAIT: begin
          if ((state == S_PAR_START && (p_num == 0 || p_den == 0)) ||
              (state == S_PAR_WAIT && md_rsp.done)) begin
            unique case (pi)
              2'd0:    tinx  <= (p_num == 0) ? '0 : p_val;
              2'd1:    tiny  <= (p_num == 0) ? '0 : p_val;
              2'd2:    toutx <= (p_num == 0) ? '0 : p_val;
              default: touty <= (p_num == 0) ? '0 : p_val;
            endcase
            pi <= pi + 2'd1;
            if (pi == 2'd1)      state <= S_DEC_IN;
            else if (pi == 2'd3) state <= S_DEC_OUT;
            else                 state <= S_PAR_START;
          end else if (state == S_PAR_START) begin
            state <= S_PAR_WAIT;
          end
        end
        S_DEC_IN: begin
          if (tin1 > T_ONE) begin
            state <= S_EDGE_DONE;
          end else if (tin1 > 0) begin
            em_x <= xin; em_y <= yin; em_gen <= 1'b1;
            ret <= S_IN2; state <= S_EMIT;
          end else begin
            state <= S_IN2;
          end
        end
        S_IN2: state <= (tin2 > T_ONE) ? S_EDGE_DONE : S_PAR_START;
        S_DEC_OUT: begin
          if (!(tin2 > 0 || tout1 > 0)) begin
            state <= S_EDGE_DONE;
          end else if (tin2 <= tout1) begin
            cr_out <= 1'b0;
            state  <= (tin2 > 0) ? S_CR_START : S_OUT_PT;
          end else begin
            em_x   <= (tinx > tiny) ? xin : xout;
            em_y   <= (tinx > tiny) ? yout : yin;
            em_gen <= 1'b1;
            ret <= S_EDGE_DONE; state <= S_EMIT;
          end
        end
        S_CR_START, S_CR_WAIT: begin
          if ((state == S_CR_START && c_zero) || (state == S_CR_WAIT && md_rsp.done)) begin
            em_x   <= ax ? c_fix : (c_zero ? c_base : c_val);
            em_y   <= ax ? (c_zero ? c_base : c_val) : c_fix;
            em_gen <= 1'b1;
            ret    <= cr_out ? S_EDGE_DONE : S_OUT_PT;
            state  <= S_EMIT;
          end else if (state == S_CR_START) begin
            state <= S_CR_WAIT;
          end
        end
        S_OUT_PT: begin
          if (tout1 < T_ONE) begin
            cr_out <= 1'b1;
            state  <= S_CR_START;
          end else begin
            em_x <= x2; em_y <= y2; em_gen <= 1'b0;
            ret <= S_EDGE_DONE; state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= {em_y, em_x};
            m_tuser  <= {1'b0, em_gen};
            m_tlast  <= 1'b0;
            if (!any_output) begin
              any_output    <= 1'b1;
              first_out_x   <= em_x;
              first_out_y   <= em_y;
              first_out_gen <= em_gen;
            end
            state <= ret;
          end
        end
        S_EDGE_DONE: begin
          // The last vertex also clips the closing edge back to the start.
          if (cur_last && !closing && (cur_x != start_x || cur_y != start_y)) begin
            closing <= 1'b1;
            e_x1 <= cur_x; e_y1 <= cur_y; e_x2 <= start_x; e_y2 <= start_y;
            state <= S_SETUP;
          end else begin
            state <= cur_last ? S_FINAL : S_IDLE;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            m_tlast    <= 1'b1;
            m_tdata    <= any_output ? {first_out_y, first_out_x} : '0;
            m_tuser    <= any_output ? {1'b0, first_out_gen} : 2'b10;
            have_prev  <= 1'b0;
            any_output <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The shared unit is only started when it is free.
  assert property (@(posedge clk) disable iff (rst) md_req.start |-> !md_rsp.busy)
    else $error("multiply-divide unit started while busy");

  // Results of the shared unit arrive only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state == S_PAR_WAIT || state == S_CR_WAIT))
    else $error("unexpected multiply-divide result");

  // The empty marker is a polygon's final word with zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == '0 && !m_tuser[0])
    else $error("malformed empty marker");

  // Closing a polygon clears the vertex history.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free) |=> !have_prev && !any_output && s_tready)
    else $error("polygon history not cleared");

endmodule

>>> rtl/core/pwc_muldiv.sv
// Shared multiply then restoring divide unit, one quotient bit per cycle.
module pwc_muldiv
  import pwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

  md_state_t     state;
  logic [CW-1:0] op_a;
  logic [CW-1:0] op_b;
  logic [CW-1:0] op_c;
  logic [CW-1:0] rem;
  logic [PW-1:0] dq;
  logic [5:0]    cnt;
  logic          done;
  logic [CW:0]   trial;
  logic          fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem, dq[PW-1]};
  assign fits  = trial >= {1'b0, op_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            op_a  <= req.a;
            op_b  <= req.b;
            op_c  <= req.c;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          dq    <= op_a * op_b;
          rem   <= '0;
          cnt   <= 6'd63;
          state <= M_DIV;
        end
        M_DIV: begin
          rem <= fits ? CW'(trial - {1'b0, op_c}) : trial[CW-1:0];
          dq  <= {dq[PW-2:0], fits};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  // The quotient saturates at the largest parameter magnitude.
  assign rsp.busy = (state != M_IDLE);
  assign rsp.done = done;
  assign rsp.q    = (dq > PW'(T_SAT)) ? T_SAT : dq[QW-1:0];

endmodule

>>> tb/polygon_window_clipper_test.sv
// Self-checking testbench for the polygon window clipper: directed table, then random polygons.
`timescale 1ns / 100ps

module polygon_window_clipper_test;
  import pwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2000;
  localparam longint PARAM_SAT  = (64'sd1 <<< 62) - 1;
  localparam longint PARAM_ONE  = 64'sd1 <<< T_FRAC;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          gen;
    logic          pend;
    logic          empty;
  } vertex_word_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
    logic          has_exp;
    vertex_word_t  exp;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata = '0;
  logic          s_tlast = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [63:0]   m_tdata;
  logic [1:0]    m_tuser;
  logic          m_tlast;

  polygon_window_clipper uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: window and vertex history.
  longint wx_min, wx_max, wy_min, wy_max;
  longint last_x, last_y, first_x, first_y, first_emit_x, first_emit_y;
  bit     seen_vertex, emitted_any, first_emit_gen;

  vertex_word_t pending_vertices[$];
  stim_row_t    directed_rows[$];
  int     errors = 0;
  int     words_in = 0;
  int     words_out = 0;
  int     idle_cycles = 0;
  int     polygons = 0;
  bit     slow_sink = 1'b0;

  function automatic longint sx32(logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Truncated a*b/c saturated at the parameter limit.
  function automatic longint scaled_quot(longint unsigned a, longint unsigned b,
                                         longint unsigned c);
    logic [127:0] p;
    logic [127:0] q;
    p = 128'(a) * 128'(b);
    q = p / 128'(c);
    return (q > 128'(PARAM_SAT)) ? PARAM_SAT : longint'(q[63:0]);
  endfunction

  function automatic longint edge_param(longint num, longint den, bit pos);
    longint unsigned m;
    if (num == 0) return 0;
    m = (den == 0) ? PARAM_SAT : scaled_quot(abs64(num), PARAM_ONE, abs64(den));
    return ((num < 0) == pos) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint meet_coord(longint base, longint num, longint dother,
                                        longint down);
    longint off, s;
    bit neg;
    if (down == 0 || num == 0 || dother == 0) return base;
    off = scaled_quot(abs64(num), abs64(dother), abs64(down));
    neg = ((num < 0) != (dother < 0)) != (down < 0);
    s = base + (neg ? -off : off);
    return s > COORD_MAX ? COORD_MAX : (s < COORD_MIN ? COORD_MIN : s);
  endfunction

  function automatic longint nudge_coord(longint c, longint lo, longint hi);
    return ((c == lo || c == hi) && c < COORD_MAX) ? c + 1 : c;
  endfunction

  // Append one expected word to the scoreboard.
  task automatic queue_word(vertex_word_t w);
    pending_vertices.insert(pending_vertices.size(), w);
  endtask

  task automatic emit_vertex(longint x, longint y, bit gen);
    vertex_word_t w;
    w.x = x[CW-1:0];
    w.y = y[CW-1:0];
    w.gen = gen;
    w.pend = 1'b0;
    w.empty = 1'b0;
    queue_word(w);
    if (!emitted_any) begin
      emitted_any = 1'b1;
      first_emit_x = x;
      first_emit_y = y;
      first_emit_gen = gen;
    end
  endtask

  task automatic clip_segment(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy, xin, xout, yin, yout, tinx, tiny, tin1, tin2, toutx, touty, tout1;
    bit px, py;
    x1 = nudge_coord(x1, wx_min, wx_max);
    x2 = nudge_coord(x2, wx_min, wx_max);
    y1 = nudge_coord(y1, wy_min, wy_max);
    y2 = nudge_coord(y2, wy_min, wy_max);
    dx = x2 - x1;
    dy = y2 - y1;
    px = dx > 0 || (dx == 0 && !(x1 > wx_min));
    py = dy > 0 || (dy == 0 && !(y1 > wy_min));
    xin = px ? wx_min : wx_max;
    xout = px ? wx_max : wx_min;
    yin = py ? wy_min : wy_max;
    yout = py ? wy_max : wy_min;
    tinx = edge_param(xin - x1, dx, px);
    tiny = edge_param(yin - y1, dy, py);
    tin1 = tinx < tiny ? tinx : tiny;
    tin2 = tinx < tiny ? tiny : tinx;
    if (tin1 > PARAM_ONE) return;
    if (tin1 > 0) emit_vertex(xin, yin, 1'b1);
    if (tin2 > PARAM_ONE) return;
    toutx = edge_param(xout - x1, dx, px);
    touty = edge_param(yout - y1, dy, py);
    tout1 = toutx < touty ? toutx : touty;
    if (!(tin2 > 0 || tout1 > 0)) return;
    if (tin2 <= tout1) begin
      if (tin2 > 0) begin
        if (tinx > tiny) emit_vertex(xin, meet_coord(y1, xin - x1, dy, dx), 1'b1);
        else emit_vertex(meet_coord(x1, yin - y1, dx, dy), yin, 1'b1);
      end
      if (tout1 < PARAM_ONE) begin
        if (toutx < touty) emit_vertex(xout, meet_coord(y1, xout - x1, dy, dx), 1'b1);
        else emit_vertex(meet_coord(x1, yout - y1, dx, dy), yout, 1'b1);
      end else begin
        emit_vertex(x2, y2, 1'b0);
      end
    end else if (tinx > tiny) begin
      emit_vertex(xin, yout, 1'b1);
    end else begin
      emit_vertex(xout, yin, 1'b1);
    end
  endtask

  // Work out the vertices one input word produces.
  task automatic predict_vertex(logic [CW-1:0] xi, logic [CW-1:0] yi, logic lst);
    longint x, y;
    vertex_word_t w;
    x = sx32(xi);
    y = sx32(yi);
    if (!seen_vertex) begin
      first_x = x;
      first_y = y;
      seen_vertex = 1'b1;
    end else begin
      clip_segment(last_x, last_y, x, y);
    end
    last_x = x;
    last_y = y;
    if (lst) begin
      if (x != first_x || y != first_y) clip_segment(x, y, first_x, first_y);
      if (emitted_any) begin
        w.x = first_emit_x[CW-1:0];
        w.y = first_emit_y[CW-1:0];
        w.gen = first_emit_gen;
        w.empty = 1'b0;
      end else begin
        w.x = '0;
        w.y = '0;
        w.gen = 1'b0;
        w.empty = 1'b1;
      end
      w.pend = 1'b1;
      queue_word(w);
      seen_vertex = 1'b0;
      emitted_any = 1'b0;
      polygons++;
    end
  endtask

  // An idle gap drops the valid; with no gap the next word follows at once.
  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Drive one word and wait for it to be taken.
  task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic lst, bit gaps);
    if (gaps) random_gap();
    s_tdata <= {y, x};
    s_tlast <= lst;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(x, y, lst);
    words_in++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_X_MIN: wx_min = sx32(val);
      REG_X_MAX: wx_max = sx32(val);
      REG_Y_MIN: wy_min = sx32(val);
      default:   wy_max = sx32(val);
    endcase
  endtask

  task automatic set_window(longint x0, longint x1, longint y0, longint y1);
    write_reg(REG_X_MIN, x0[CW-1:0]);
    write_reg(REG_X_MAX, x1[CW-1:0]);
    write_reg(REG_Y_MIN, y0[CW-1:0]);
    write_reg(REG_Y_MAX, y1[CW-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Coordinates near the window, with a few anywhere in range.
  function automatic logic [CW-1:0] pick_coord(longint lo, longint hi);
    longint span, c;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return lo[CW-1:0];
      2: return hi[CW-1:0];
      default: begin
        span = (hi > lo ? hi - lo : lo - hi) + 64'sd4096;
        c = ((lo < hi) ? lo : hi) - span / 2 +
            longint'({$urandom(), $urandom()} % 64'(2 * span));
        return c[CW-1:0];
      end
    endcase
  endfunction

  // Result side: random stalls, field-wise comparison.
  always @(negedge clk) begin
    if (slow_sink || $urandom_range(0, 19) == 0) m_tready <= ($urandom_range(0, 3) == 0);
    else m_tready <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    vertex_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (pending_vertices.size() == 0) begin
        $error("unexpected output word x=%h y=%h", m_tdata[31:0], m_tdata[63:32]);
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (m_tdata[31:0] !== e.x) begin
          $error("out_x expected %h actual %h", e.x, m_tdata[31:0]); errors++;
        end
        if (m_tdata[63:32] !== e.y) begin
          $error("out_y expected %h actual %h", e.y, m_tdata[63:32]); errors++;
        end
        if (m_tuser[0] !== e.gen) begin
          $error("generated expected %b actual %b", e.gen, m_tuser[0]); errors++;
        end
        if (m_tlast !== e.pend) begin
          $error("polygon_end expected %b actual %b", e.pend, m_tlast); errors++;
        end
        if (m_tuser[1] !== e.empty) begin
          $error("empty_res expected %b actual %b", e.empty, m_tuser[1]); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_vertices.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic stim_row_t mk_row(longint x, longint y, bit lst, bit has,
                                       vertex_word_t ew);
    stim_row_t r;
    r.x = x[CW-1:0];
    r.y = y[CW-1:0];
    r.last = lst;
    r.has_exp = has;
    r.exp = ew;
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(longint x, longint y, bit lst, bit has, vertex_word_t ew);
    directed_rows.insert(directed_rows.size(), mk_row(x, y, lst, has, ew));
  endtask

  initial begin
    vertex_word_t empty_mark, none;
    longint one, wlo, whi;
    int nv, v;
    empty_mark = '{x: '0, y: '0, gen: 1'b0, pend: 1'b1, empty: 1'b1};
    none = '0;
    one = 64'sd65536;
    wx_min = 0; wx_max = 0; wy_min = 0; wy_max = 0;
    seen_vertex = 0; emitted_any = 0; first_emit_gen = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed table. Single vertex and the zero window give empty markers.
    add_row(5 * one, 5 * one, 1, 1, empty_mark);
    add_row(COORD_MAX, COORD_MIN, 1, 1, empty_mark);
    // Square straddling the window: entry, exit, corner and on-edge points.
    add_row(-one, -one, 0, 0, none);
    add_row(20 * one, -one, 0, 0, none);
    add_row(20 * one, 20 * one, 0, 0, none);
    add_row(-one, 20 * one, 1, 0, none);
    // Inside triangle with a vertex on the left edge.
    add_row(0, 3 * one, 0, 0, none);
    add_row(5 * one, 2 * one, 0, 0, none);
    add_row(5 * one, 8 * one, 1, 0, none);
    // Closing vertex repeating the first, vertical and horizontal edges.
    add_row(2 * one, -5 * one, 0, 0, none);
    add_row(2 * one, 15 * one, 0, 0, none);
    add_row(-5 * one, 15 * one, 0, 0, none);
    add_row(2 * one, -5 * one, 1, 0, none);
    // Fully outside polygon gives one marker.
    add_row(40 * one, 40 * one, 0, 0, none);
    add_row(50 * one, 40 * one, 0, 0, none);
    add_row(45 * one, 60 * one, 1, 1, empty_mark);
    // Extreme coordinates.
    add_row(COORD_MIN, COORD_MIN, 0, 0, none);
    add_row(COORD_MAX, COORD_MIN, 0, 0, none);
    add_row(COORD_MAX, COORD_MAX, 0, 0, none);
    add_row(COORD_MIN, COORD_MAX, 1, 0, none);

    // First two rows run against the reset (all-zero) window.
    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == 2) begin
        wait_drained();
        set_window(0, 10 * one, 0, 10 * one);
      end
      if (directed_rows[i].has_exp) begin
        wait_drained();
        send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last, 0);
        if (pending_vertices.size() != 0 && pending_vertices[$] !== directed_rows[i].exp) begin
          $error("directed row %0d: predictor disagrees with table", i);
          errors++;
        end
      end else begin
        send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last, 1);
      end
    end

    // Random polygons over several windows, including inverted and extreme ones.
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: set_window(-3 * one, 7 * one, -2 * one, 9 * one);
        1: set_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        2: set_window(8 * one, -8 * one, 5 * one, -5 * one);
        3: set_window(COORD_MAX - one, COORD_MAX, COORD_MIN, COORD_MIN + one);
        4: set_window(sx32($urandom()), sx32($urandom()), sx32($urandom()),
                      sx32($urandom()));
        default: set_window(-one, one, -one, one);
      endcase
      wlo = wx_min;
      whi = wx_max;
      slow_sink = (phase == 2);
      for (int p = 0; p < 5; p++) begin
        nv = $urandom_range(1, 5);
        for (v = 0; v < nv; v++) begin
          if (v == nv - 1 && nv > 2 && $urandom_range(0, 4) == 0)
            send_vertex(first_x[CW-1:0], first_y[CW-1:0], 1'b1, 1);
          else
            send_vertex(pick_coord(wlo, whi), pick_coord(wy_min, wy_max),
                        v == nv - 1, 1);
        end
      end
    end
    slow_sink = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d vertices in %0d polygons, checked %0d output words,", words_in,
             polygons, words_out);
    $display("covering reset, inverted, extreme and random windows under random stalls.");
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
